FILE: rtl/tcpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpf_pkg
// Shared constants, codes and controller/datapath interface types for the
// time cluster peak finder.
// ----------------------------------------------------------------------------
package tcpf_pkg;

   localparam int MAX_DIGITS    = 64;
   localparam int MAX_RESULTS   = 64;
   localparam int HALF_WINDOW   = 2;
   localparam int EDGE_MIN_SPAN = 2;
   localparam int EDGE_MIN_PEAK = 5;

   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int IDX_W  = CNT_W + 1;
   localparam int K_W    = $clog2(MAX_RESULTS + 1);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 29;

   localparam logic [CSR_IDX_W-1:0] CSR_DECONVOLUTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPROVED_SPLIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_WINDOW_ON  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_LIMIT    = 2'd3;

   localparam logic [1:0] FLAG_IGNORED = 2'd0;
   localparam logic [1:0] FLAG_DATA    = 2'd1;
   localparam logic [1:0] FLAG_TRAILER = 2'd2;
   localparam logic [1:0] FLAG_OTHER   = 2'd3;

   localparam logic [1:0] MARK_PLAIN = 2'd0;
   localparam logic [1:0] MARK_PEAK  = 2'd1;
   localparam logic [1:0] MARK_MIN   = 2'd2;
   localparam logic [1:0] MARK_UNDEF = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              hdr_load;
      logic [ADDR_W-1:0] rd_addr;
      logic              acc_clear;
      logic              mul1;
      logic              mul2;
      logic              mul3;
      logic              pt_load;
      logic              frag_make;
      logic              frag_fwd;
      logic              frag_row_q;
      logic              frag_edge;
      logic              frag_split;
      logic              push;
      logic              push_last;
   } cmd_type;

   typedef struct packed {
      logic [15:0] rd_q;
      logic [1:0]  rd_mark;
      logic [1:0]  hdr_flag;
      logic        hdr_edge;
      logic        sum_small;
      logic        out_free;
      logic        deconvolute;
      logic        improved_split;
      logic        time_window_on;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/tcpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpf_dp
// Datapath: configuration registers, digit store, bunch header, gained charge
// multiply-accumulate, pending fragment and output register.
// ----------------------------------------------------------------------------
module tcpf_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [tcpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcpf_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  wire logic [1:0]                     req_bunch_flag,
   input  wire logic [7:0]                     req_row,
   input  wire logic [7:0]                     req_pad,
   input  wire logic                           req_branch,
   input  wire logic                           req_edge_pad,
   input  wire logic [12:0]                    req_gain,
   input  wire logic [15:0]                    req_charge,
   input  wire logic [9:0]                     req_time_bin,
   input  wire logic [1:0]                     req_peak_mark,
   input  wire tcpf_pkg::cmd_type              cmd,
   output tcpf_pkg::status_type                st,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_out_flag,
   output logic [15:0]                         rsp_out_row,
   output logic [7:0]                          rsp_out_pad,
   output logic                                rsp_out_branch,
   output logic                                rsp_edge_cluster,
   output logic [28:0]                         rsp_q_max,
   output logic [34:0]                         rsp_q_sum,
   output logic [44:0]                         rsp_qt_sum,
   output logic [54:0]                         rsp_qtt_sum,
   output logic [9:0]                          rsp_peak_time,
   output logic                                rsp_split_in_time,
   output logic                                rsp_last_of_run
);
   import tcpf_pkg::*;

   logic        dec_ff, imp_ff, win_ff;
   logic [28:0] lim_ff;

   logic [27:0] mem [MAX_DIGITS];
   logic [27:0] rd_ff;

   logic [1:0]  hflag_ff;
   logic [7:0]  hrow_ff, hpad_ff;
   logic        hbr_ff, hedge_ff;
   logic [12:0] hgain_ff;

   logic [28:0] q_ff;
   logic [9:0]  t_ff;
   logic [38:0] qt_ff;
   logic [28:0] qmax_ff;
   logic [34:0] qs_ff;
   logic [44:0] qts_ff;
   logic [54:0] qtts_ff;
   logic [9:0]  pt_ff;

   logic [1:0]  p_flag_ff;
   logic [15:0] p_row_ff;
   logic [7:0]  p_pad_ff;
   logic        p_br_ff, p_edge_ff, p_split_ff;
   logic [28:0] p_qmax_ff;
   logic [34:0] p_qs_ff;
   logic [44:0] p_qt_ff;
   logic [54:0] p_qtt_ff;
   logic [9:0]  p_pt_ff;

   logic        rsp_valid_ff;

   logic [15:0] rd_q;
   logic [9:0]  rd_t;
   logic [28:0] prod1;
   logic [38:0] prod2;
   logic [48:0] prod3;
   logic        out_free;

   assign rd_q     = rd_ff[27:12];
   assign rd_t     = rd_ff[11:2];
   assign prod1    = rd_q * hgain_ff;
   assign prod2    = q_ff * t_ff;
   assign prod3    = qt_ff * t_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      st.rd_q           = rd_q;
      st.rd_mark        = rd_ff[1:0];
      st.hdr_flag       = hflag_ff;
      st.hdr_edge       = hedge_ff;
      st.sum_small      = qs_ff < {6'd0, lim_ff};
      st.out_free       = out_free;
      st.deconvolute    = dec_ff;
      st.improved_split = imp_ff;
      st.time_window_on = win_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= 1'b0;
         imp_ff <= 1'b0;
         win_ff <= 1'b0;
         lim_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DECONVOLUTE:    dec_ff <= csr_wdata[0];
            CSR_IMPROVED_SPLIT: imp_ff <= csr_wdata[0];
            CSR_TIME_WINDOW_ON: win_ff <= csr_wdata[0];
            CSR_SINGLE_LIMIT:   lim_ff <= csr_wdata;
            default:            dec_ff <= dec_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {req_charge, req_time_bin, req_peak_mark};
      end
      rd_ff <= mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.hdr_load) begin
         hflag_ff <= req_bunch_flag;
         hrow_ff  <= req_row;
         hpad_ff  <= req_pad;
         hbr_ff   <= req_branch;
         hedge_ff <= req_edge_pad;
         hgain_ff <= req_gain;
      end
   end

   // gained charge, then charge*time, then charge*time^2, one product per cycle
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         qmax_ff <= '0;
         qs_ff   <= '0;
         qts_ff  <= '0;
         qtts_ff <= '0;
      end
      if (cmd.mul1) begin
         q_ff <= prod1;
         t_ff <= rd_t;
      end
      if (cmd.mul2) begin
         qt_ff <= prod2;
      end
      if (cmd.mul3) begin
         if (q_ff > qmax_ff) begin
            qmax_ff <= q_ff;
         end
         qs_ff   <= qs_ff + 35'(q_ff);
         qts_ff  <= qts_ff + 45'(qt_ff);
         qtts_ff <= qtts_ff + 55'(prod3);
      end
      if (cmd.pt_load) begin
         pt_ff <= rd_t;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frag_make) begin
         p_flag_ff <= hflag_ff;
         p_row_ff  <= cmd.frag_row_q ? rd_q : {8'd0, hrow_ff};
         p_pad_ff  <= hpad_ff;
         p_br_ff   <= hbr_ff;
         if (cmd.frag_fwd) begin
            p_edge_ff  <= 1'b0;
            p_split_ff <= 1'b0;
            p_qmax_ff  <= '0;
            p_qs_ff    <= '0;
            p_qt_ff    <= '0;
            p_qtt_ff   <= '0;
            p_pt_ff    <= '0;
         end else begin
            p_edge_ff  <= cmd.frag_edge;
            p_split_ff <= cmd.frag_split;
            p_qmax_ff  <= qmax_ff;
            p_qs_ff    <= qs_ff;
            p_qt_ff    <= qts_ff;
            p_qtt_ff   <= qtts_ff;
            p_pt_ff    <= pt_ff;
         end
      end
      if (cmd.push) begin
         rsp_out_flag      <= p_flag_ff;
         rsp_out_row       <= p_row_ff;
         rsp_out_pad       <= p_pad_ff;
         rsp_out_branch    <= p_br_ff;
         rsp_edge_cluster  <= p_edge_ff;
         rsp_q_max         <= p_qmax_ff;
         rsp_q_sum         <= p_qs_ff;
         rsp_qt_sum        <= p_qt_ff;
         rsp_qtt_sum       <= p_qtt_ff;
         rsp_peak_time     <= p_pt_ff;
         rsp_split_in_time <= p_split_ff;
         rsp_last_of_run   <= cmd.push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a held item must never be overwritten
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free) else $error("push onto a held item");

endmodule
`default_nettype wire

FILE: rtl/tcpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpf_ctrl
// Controller: digit loading, peak search, cluster bounding and fragment
// sequencing for one bunch at a time.
// ----------------------------------------------------------------------------
module tcpf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_stall,
   input  wire tcpf_pkg::status_type st,
   output tcpf_pkg::cmd_type         cmd
);
   import tcpf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_LOOP, S_PREQ, S_PCHK, S_PEAK, S_MREQ, S_MCHK,
      S_LOREQ, S_LOCHK, S_SREQ, S_SCHK, S_LAREQ, S_LACHK, S_BOUND, S_TREQ,
      S_TLAT, S_AREQ, S_AM1, S_AM2, S_AM3, S_CHECK, S_FRAG, S_FWDREQ, S_FWD,
      S_END
   } state_type;

   localparam logic [IDX_W-1:0] HW = IDX_W'(HALF_WINDOW);

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] idx_ff, ip_ff, i0_ff, iend_ff, j_ff;
   logic [1:0]       off_ff;
   logic [15:0]      qp_ff;
   logic             dec_ff, was_ff, split_ff, pend_ff;
   logic [K_W-1:0]   k_ff;

   logic             accept;
   logic [IDX_W-1:0] n, idx_p1, ip_p2, ip_p3, i0_p2, la_addr, win_lo, fb_idx;
   logic             frag_go;

   assign n       = IDX_W'(cnt_ff);
   assign accept  = req_valid && (state_ff == S_IDLE);
   assign idx_p1  = idx_ff + 1'b1;
   assign ip_p2   = ip_ff + HW;
   assign ip_p3   = ip_p2 + 1'b1;
   assign i0_p2   = i0_ff + HW;
   assign la_addr = idx_ff + IDX_W'(off_ff);
   assign win_lo  = (ip_ff > i0_p2) ? (ip_ff - HW) : i0_ff;
   // no marked peak ahead: step over one or two digits, or none at the end of the store
   assign fb_idx  = (idx_p1 < n) ? (idx_ff + 2'd2) : ((idx_ff < n) ? idx_p1 : idx_ff);
   assign frag_go = !pend_ff || st.out_free;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.wr_en    = accept && (cnt_ff < CNT_W'(MAX_DIGITS));
      cmd.wr_addr  = cnt_ff[ADDR_W-1:0];
      cmd.hdr_load = accept && (cnt_ff == '0);
      case (state_ff)
         S_LOREQ, S_AREQ: cmd.rd_addr = j_ff[ADDR_W-1:0];
         S_LAREQ:         cmd.rd_addr = la_addr[ADDR_W-1:0];
         S_TREQ:          cmd.rd_addr = ip_ff[ADDR_W-1:0];
         S_FWDREQ:        cmd.rd_addr = '0;
         default:         cmd.rd_addr = idx_ff[ADDR_W-1:0];
      endcase
      cmd.frag_edge  = st.hdr_edge && (iend_ff > i0_ff + IDX_W'(EDGE_MIN_SPAN))
                       && (qp_ff > 16'(EDGE_MIN_PEAK));
      cmd.frag_split = split_ff;
      cmd.frag_row_q = (st.hdr_flag == FLAG_TRAILER) && (cnt_ff == CNT_W'(1));
      case (state_ff)
         S_LOOP: cmd.acc_clear = 1'b1;
         S_TLAT: cmd.pt_load   = 1'b1;
         S_AM1:  cmd.mul1      = 1'b1;
         S_AM2:  cmd.mul2      = 1'b1;
         S_AM3:  cmd.mul3      = 1'b1;
         S_FRAG: begin
            cmd.frag_make = frag_go;
            cmd.push      = frag_go && pend_ff;
         end
         S_FWD: begin
            cmd.frag_make = frag_go;
            cmd.frag_fwd  = 1'b1;
            cmd.push      = frag_go && pend_ff;
         end
         S_END: begin
            cmd.push      = pend_ff && st.out_free;
            cmd.push_last = 1'b1;
         end
         default: cmd.push_last = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (cnt_ff < CNT_W'(MAX_DIGITS)) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
                  if (req_last) begin
                     state_ff <= S_DISPATCH;
                  end
               end
            end
            S_DISPATCH: begin
               idx_ff <= '0;
               was_ff <= 1'b0;
               k_ff   <= '0;
               if (st.hdr_flag == FLAG_IGNORED) begin
                  state_ff <= S_END;
               end else if (st.hdr_flag == FLAG_DATA) begin
                  state_ff <= S_LOOP;
               end else begin
                  state_ff <= S_FWDREQ;
               end
            end
            S_LOOP: begin
               i0_ff  <= idx_ff;
               ip_ff  <= idx_ff;
               qp_ff  <= '0;
               dec_ff <= 1'b0;
               if ((k_ff == K_W'(MAX_RESULTS)) || (idx_ff >= n)) begin
                  state_ff <= S_END;
               end else begin
                  state_ff <= S_PREQ;
               end
            end
            S_PREQ: state_ff <= (idx_ff >= n) ? S_PEAK : S_PCHK;
            S_PCHK: begin
               idx_ff <= idx_p1;
               if (st.rd_mark != MARK_PEAK) begin
                  state_ff <= S_PREQ;
               end else if (st.deconvolute) begin
                  ip_ff    <= idx_ff;
                  qp_ff    <= st.rd_q;
                  state_ff <= S_PEAK;
               end else begin
                  if (st.rd_q > qp_ff) begin
                     qp_ff <= st.rd_q;
                     ip_ff <= idx_ff;
                  end
                  state_ff <= S_PREQ;
               end
            end
            S_PEAK: begin
               if (qp_ff == '0) begin
                  state_ff <= S_END;
               end else if (!st.deconvolute) begin
                  idx_ff   <= n;
                  state_ff <= S_BOUND;
               end else if (!st.time_window_on) begin
                  state_ff <= S_MREQ;
               end else if (st.improved_split) begin
                  was_ff   <= 1'b0;
                  j_ff     <= win_lo;
                  state_ff <= S_LOREQ;
               end else begin
                  off_ff   <= 2'd1;
                  state_ff <= S_LAREQ;
               end
            end
            S_MREQ: state_ff <= (idx_ff >= n) ? S_BOUND : S_MCHK;
            S_MCHK: begin
               idx_ff <= idx_p1;
               if (st.rd_mark != MARK_PLAIN) begin
                  dec_ff   <= (idx_p1 < n);
                  state_ff <= S_BOUND;
               end else begin
                  state_ff <= S_MREQ;
               end
            end
            S_LOREQ: state_ff <= (j_ff >= ip_ff) ? S_SREQ : S_LOCHK;
            S_LOCHK: begin
               if (st.rd_mark == MARK_MIN) begin
                  i0_ff  <= j_ff + 1'b1;
                  was_ff <= 1'b1;
               end
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_LOREQ;
            end
            S_SREQ: begin
               if (idx_ff >= n) begin
                  state_ff <= S_BOUND;
               end else if (idx_ff == ip_p2) begin
                  idx_ff   <= idx_p1;
                  state_ff <= S_BOUND;
               end else begin
                  state_ff <= S_SCHK;
               end
            end
            S_SCHK: begin
               idx_ff <= idx_p1;
               if (st.rd_mark == MARK_MIN) begin
                  dec_ff   <= (idx_p1 != n);
                  state_ff <= S_BOUND;
               end else begin
                  state_ff <= S_SREQ;
               end
            end
            S_LAREQ: begin
               if (la_addr < n) begin
                  state_ff <= S_LACHK;
               end else begin
                  idx_ff   <= fb_idx;
                  state_ff <= S_BOUND;
               end
            end
            S_LACHK: begin
               if (st.rd_mark == MARK_PEAK) begin
                  idx_ff   <= (off_ff == 2'd3) ? idx_ff + 2'd2 : idx_p1;
                  dec_ff   <= 1'b1;
                  state_ff <= S_BOUND;
               end else if (off_ff == 2'd3) begin
                  idx_ff   <= fb_idx;
                  state_ff <= S_BOUND;
               end else begin
                  off_ff   <= off_ff + 1'b1;
                  state_ff <= S_LAREQ;
               end
            end
            S_BOUND: begin
               if (st.time_window_on) begin
                  i0_ff   <= win_lo;
                  j_ff    <= win_lo;
                  iend_ff <= (idx_ff > ip_p3) ? ip_p3 : idx_ff;
               end else begin
                  j_ff    <= i0_ff;
                  iend_ff <= idx_ff;
               end
               split_ff <= was_ff || dec_ff;
               was_ff   <= dec_ff;
               state_ff <= S_TREQ;
            end
            S_TREQ: state_ff <= S_TLAT;
            S_TLAT: state_ff <= S_AREQ;
            S_AREQ: state_ff <= ((j_ff >= iend_ff) || (j_ff >= n)) ? S_CHECK : S_AM1;
            S_AM1:  state_ff <= S_AM2;
            S_AM2:  state_ff <= S_AM3;
            S_AM3: begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_AREQ;
            end
            S_CHECK: begin
               // a lone digit below the limit ends the bunch without an item
               if ((cnt_ff == CNT_W'(1)) && st.sum_small) begin
                  state_ff <= S_END;
               end else begin
                  state_ff <= S_FRAG;
               end
            end
            S_FRAG: begin
               if (frag_go) begin
                  pend_ff  <= 1'b1;
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_LOOP;
               end
            end
            S_FWDREQ: state_ff <= S_FWD;
            S_FWD: begin
               if (frag_go) begin
                  pend_ff  <= 1'b1;
                  state_ff <= S_END;
               end
            end
            S_END: begin
               if (!pend_ff || st.out_free) begin
                  pend_ff  <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIGITS)) else $error("digit count past store depth");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_W'(MAX_RESULTS)) else $error("too many items for one bunch");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff) else $error("pending item left at idle");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END && !pend_ff) |=> (cnt_ff == '0))
      else $error("digit count not cleared after bunch");

endmodule
`default_nettype wire

FILE: rtl/time_cluster_peak_finder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_cluster_peak_finder_unit
// Loads one pad bunch digit by digit, then emits its cluster fragments.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one digit per item; the bunch header is taken from the first
//  digit and the bunch is processed once the digit with req_last arrives.
//  Digits are taken at one per cycle while loading. During processing
//  req_stall stays high.
//  Processing visits the stored digits through one registered read port in
//  the peak scan and in each bounding scan, and each digit summed goes
//  through three chained multiplies; each fragment and each bunch add their
//  own steps. A forwarded word or an ignored bunch also stalls the input
//  while it is handled.
//  Fragments leave through rsp_*; one is held back so that the final one can
//  carry rsp_last_of_run. A stalled rsp_* item holds; the controller waits.
//  csr_* writes the mode and limit registers; write them only while the block
//  is idle, which the block itself does not enforce. Synchronous reset clears
//  the controller, the mode and limit registers and rsp_valid; the digit store is not cleared.
// ----------------------------------------------------------------------------
module time_cluster_peak_finder_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [tcpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcpf_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_bunch_flag,
   input  wire logic [7:0]                     req_row,
   input  wire logic [7:0]                     req_pad,
   input  wire logic                           req_branch,
   input  wire logic                           req_edge_pad,
   input  wire logic [12:0]                    req_gain,
   input  wire logic [15:0]                    req_charge,
   input  wire logic [9:0]                     req_time_bin,
   input  wire logic [1:0]                     req_peak_mark,
   input  wire logic                           req_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_out_flag,
   output logic [15:0]                         rsp_out_row,
   output logic [7:0]                          rsp_out_pad,
   output logic                                rsp_out_branch,
   output logic                                rsp_edge_cluster,
   output logic [28:0]                         rsp_q_max,
   output logic [34:0]                         rsp_q_sum,
   output logic [44:0]                         rsp_qt_sum,
   output logic [54:0]                         rsp_qtt_sum,
   output logic [9:0]                          rsp_peak_time,
   output logic                                rsp_split_in_time,
   output logic                                rsp_last_of_run
);
   import tcpf_pkg::*;

   cmd_type    cmd;
   status_type st;

   tcpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tcpf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_bunch_flag    (req_bunch_flag),
      .req_row           (req_row),
      .req_pad           (req_pad),
      .req_branch        (req_branch),
      .req_edge_pad      (req_edge_pad),
      .req_gain          (req_gain),
      .req_charge        (req_charge),
      .req_time_bin      (req_time_bin),
      .req_peak_mark     (req_peak_mark),
      .cmd               (cmd),
      .st                (st),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_flag      (rsp_out_flag),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_pad       (rsp_out_pad),
      .rsp_out_branch    (rsp_out_branch),
      .rsp_edge_cluster  (rsp_edge_cluster),
      .rsp_q_max         (rsp_q_max),
      .rsp_q_sum         (rsp_q_sum),
      .rsp_qt_sum        (rsp_qt_sum),
      .rsp_qtt_sum       (rsp_qtt_sum),
      .rsp_peak_time     (rsp_peak_time),
      .rsp_split_in_time (rsp_split_in_time),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
`default_nettype wire
